[hdl/fblr_pkg.sv]
package fblr_pkg;

  localparam int FBLR_PANEL_WIDTH  = 84;
  localparam int FBLR_PANEL_HEIGHT = 48;
  localparam int FBLR_STORE_BYTES  = 504;

  // wide enough for any pixel byte index and any read index
  localparam int IDX_W = 14;

  localparam int OP_W    = 2;
  localparam int COORD_W = 8;
  localparam int RIDX_W  = 9;
  localparam int BYTE_W  = 8;
  localparam int ROT_W   = 2;

  localparam logic [OP_W-1:0] OP_LINE  = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_FILL  = 2'd2;
  localparam logic [OP_W-1:0] OP_READ  = 2'd3;

  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic [2:0]       bit_sel;
  } fblr_pix_t;

endpackage

[hdl/fblr_channels.sv]
interface fblr_in_if;
  logic                         valid;
  logic                         ready;
  logic [fblr_pkg::OP_W-1:0]    operation;
  logic [fblr_pkg::COORD_W-1:0] start_x;
  logic [fblr_pkg::COORD_W-1:0] start_y;
  logic [fblr_pkg::COORD_W-1:0] end_x;
  logic [fblr_pkg::COORD_W-1:0] end_y;
  logic                         ink;
  logic [fblr_pkg::RIDX_W-1:0]  read_index;

  modport source (output valid, operation, start_x, start_y, end_x, end_y, ink, read_index,
                  input ready);
  modport sink (input valid, operation, start_x, start_y, end_x, end_y, ink, read_index,
                output ready);
endinterface

interface fblr_out_if;
  logic                        valid;
  logic                        ready;
  logic [fblr_pkg::BYTE_W-1:0] read_byte;
  logic                        done_res;

  modport source (output valid, read_byte, done_res, input ready);
  modport sink (input valid, read_byte, done_res, output ready);
endinterface

interface fblr_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [fblr_pkg::ROT_W-1:0] rotation;

  modport source (output valid, rotation, input ready);
  modport sink (input valid, rotation, output ready);
endinterface

[hdl/fblr_plot_map.sv]
module fblr_plot_map #(
  parameter int PANEL_WIDTH  = fblr_pkg::FBLR_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = fblr_pkg::FBLR_PANEL_HEIGHT,
  parameter int STORE_BYTES  = fblr_pkg::FBLR_STORE_BYTES
) (
  input  logic [fblr_pkg::COORD_W-1:0] x,
  input  logic [fblr_pkg::COORD_W-1:0] y,
  input  logic [fblr_pkg::ROT_W-1:0]   rotation,
  output fblr_pkg::fblr_pix_t          pix
);
  import fblr_pkg::*;

  localparam logic [COORD_W-1:0] W8    = COORD_W'(PANEL_WIDTH);
  localparam logic [COORD_W-1:0] H8    = COORD_W'(PANEL_HEIGHT);
  localparam logic [IDX_W-1:0]   W_IDX = IDX_W'(PANEL_WIDTH);
  localparam logic [IDX_W-1:0]   LIMIT = IDX_W'(STORE_BYTES);

  logic [COORD_W-1:0] clip_w;
  logic [COORD_W-1:0] clip_h;
  logic               in_clip;
  logic [COORD_W-1:0] px;
  logic [COORD_W-1:0] py;
  logic [IDX_W-1:0]   idx;

  assign clip_w  = rotation[0] ? H8 : W8;
  assign clip_h  = rotation[0] ? W8 : H8;
  assign in_clip = (x < clip_w) && (y < clip_h);

  always_comb begin
    case (rotation)
      ROT_90: begin
        px = y;
        py = H8 - 8'd1 - x;
      end
      ROT_180: begin
        px = W8 - 8'd1 - x;
        py = H8 - 8'd1 - y;
      end
      ROT_270: begin
        px = W8 - 8'd1 - y;
        py = x;
      end
      default: begin
        px = x;
        py = y;
      end
    endcase
  end

  assign idx = IDX_W'(px) + IDX_W'(py[7:3]) * W_IDX;

  assign pix.hit     = in_clip && (idx < LIMIT);
  assign pix.idx     = idx;
  assign pix.bit_sel = py[2:0];

endmodule

[hdl/framebuffer_line_rasterizer_unit.sv]
// channel  | dir | handshake   | payload
// in_ch    | in  | valid/ready | operation, start_x, start_y, end_x, end_y, ink, read_index
// out_ch   | out | valid/ready | read_byte, done_res
// cfg_ch   | in  | valid/ready | rotation
//
// one item at a time: a line reads then writes the store for each pixel of its major span,
// clear and fill write all STORE_BYTES bytes, and a read does one store read
// after reset a clearing pass writes zero to all STORE_BYTES bytes, in_ch not ready meanwhile
// a finished result waits in the output register while the next item is accepted
// cfg_ch is always ready
module framebuffer_line_rasterizer_unit #(
  parameter int PANEL_WIDTH  = fblr_pkg::FBLR_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = fblr_pkg::FBLR_PANEL_HEIGHT,
  parameter int STORE_BYTES  = fblr_pkg::FBLR_STORE_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  fblr_in_if.sink    in_ch,
  fblr_out_if.source out_ch,
  fblr_cfg_if.sink   cfg_ch
);
  import fblr_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(STORE_BYTES - 1);
  localparam logic [IDX_W-1:0] LIMIT     = IDX_W'(STORE_BYTES);

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_LRD   = 3'd3;
  localparam logic [2:0] S_LWR   = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic               wipe_r, wipe_nxt;
  logic [AW-1:0]      sweep_r, sweep_nxt;
  logic [ROT_W-1:0]   rotation_r;
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r, out_byte_nxt;

  // captured item
  logic [OP_W-1:0]    op_r;
  logic [COORD_W-1:0] sx_r, sy_r, ex_r, ey_r;
  logic               ink_r;
  logic [RIDX_W-1:0]  ridx_r;

  // line walk
  logic               steep_r, steep_nxt;
  logic               up_r, up_nxt;
  logic [COORD_W-1:0] maj_r, maj_nxt;
  logic [COORD_W-1:0] min_r, min_nxt;
  logic [COORD_W-1:0] cnt_r, cnt_nxt;
  logic [COORD_W-1:0] dx_r, dx_nxt;
  logic [COORD_W-1:0] dy_r, dy_nxt;
  logic signed [9:0]  err_r, err_nxt;
  logic               hit_r;
  logic [AW-1:0]      waddr_r;
  logic [2:0]         bit_r;

  // frame store
  logic [BYTE_W-1:0]  mem [STORE_BYTES];
  logic [BYTE_W-1:0]  mem_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [BYTE_W-1:0]  mem_wdata;

  logic               in_acc;
  logic [COORD_W-1:0] adx, ady;
  logic               steep_c;
  logic [COORD_W-1:0] p0, q0, p1, q1;
  logic [COORD_W-1:0] qs, qe;
  logic [COORD_W-1:0] px_c, py_c;
  fblr_pix_t          pix;
  logic signed [9:0]  err_sub;
  logic [BYTE_W-1:0]  mask;
  logic [IDX_W-1:0]   ridx_ext;
  logic               ridx_ok;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.read_byte = out_byte_r;
  assign out_ch.done_res  = 1'b1;

  // steep swap and endpoint swap
  assign adx     = (ex_r > sx_r) ? (ex_r - sx_r) : (sx_r - ex_r);
  assign ady     = (ey_r > sy_r) ? (ey_r - sy_r) : (sy_r - ey_r);
  assign steep_c = ady > adx;
  assign p0 = steep_c ? sy_r : sx_r;
  assign q0 = steep_c ? sx_r : sy_r;
  assign p1 = steep_c ? ey_r : ex_r;
  assign q1 = steep_c ? ex_r : ey_r;
  assign qs = (p0 > p1) ? q1 : q0;
  assign qe = (p0 > p1) ? q0 : q1;

  assign px_c = steep_r ? min_r : maj_r;
  assign py_c = steep_r ? maj_r : min_r;

  fblr_plot_map #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .STORE_BYTES  (STORE_BYTES)
  ) u_map (
    .x        (px_c),
    .y        (py_c),
    .rotation (rotation_r),
    .pix      (pix)
  );

  assign err_sub  = err_r - $signed({2'b00, dy_r});
  assign mask     = BYTE_W'(1) << bit_r;
  assign ridx_ext = IDX_W'(ridx_r);
  assign ridx_ok  = ridx_ext < LIMIT;

  always_comb begin
    state_nxt     = state_r;
    wipe_nxt      = wipe_r;
    sweep_nxt     = sweep_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    steep_nxt     = steep_r;
    up_nxt        = up_r;
    maj_nxt       = maj_r;
    min_nxt       = min_r;
    cnt_nxt       = cnt_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    err_nxt       = err_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = sweep_r;
    mem_wdata     = '0;
    mem_raddr     = pix.idx[AW-1:0];

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
        mem_wdata = (!wipe_r && op_r == OP_FILL) ? 8'hFF : 8'h00;
        if (sweep_r == LAST_ADDR) begin
          sweep_nxt = '0;
          wipe_nxt  = 1'b0;
          state_nxt = wipe_r ? S_IDLE : S_FIN;
        end else begin
          sweep_nxt = sweep_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_ch.operation)
            OP_LINE:  state_nxt = S_SETUP;
            OP_READ:  state_nxt = S_RD;
            default:  state_nxt = S_SWEEP;
          endcase
        end
      end
      S_SETUP: begin
        steep_nxt = steep_c;
        maj_nxt   = (p0 > p1) ? p1 : p0;
        min_nxt   = qs;
        up_nxt    = qs < qe;
        dx_nxt    = steep_c ? ady : adx;
        dy_nxt    = steep_c ? adx : ady;
        cnt_nxt   = steep_c ? ady : adx;
        err_nxt   = $signed({3'b000, (steep_c ? ady[7:1] : adx[7:1])});
        state_nxt = S_LRD;
      end
      S_LRD: begin
        mem_re    = 1'b1;
        mem_raddr = pix.idx[AW-1:0];
        state_nxt = S_LWR;
      end
      S_LWR: begin
        mem_we    = hit_r;
        mem_waddr = waddr_r;
        mem_wdata = ink_r ? (mem_q | mask) : (mem_q & ~mask);
        maj_nxt   = maj_r + 8'd1;
        if (err_sub < 0) begin
          min_nxt = up_r ? (min_r + 8'd1) : (min_r - 8'd1);
          err_nxt = err_sub + $signed({2'b00, dx_r});
        end else begin
          err_nxt = err_sub;
        end
        cnt_nxt = cnt_r - 8'd1;
        state_nxt = (cnt_r == 8'd0) ? S_FIN : S_LRD;
      end
      S_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ridx_ext[AW-1:0];
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = (op_r == OP_READ && ridx_ok) ? mem_q : 8'h00;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      wipe_r      <= 1'b1;
      sweep_r     <= '0;
      rotation_r  <= ROT_0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wipe_r      <= wipe_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        rotation_r <= cfg_ch.rotation;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    steep_r    <= steep_nxt;
    up_r       <= up_nxt;
    maj_r      <= maj_nxt;
    min_r      <= min_nxt;
    cnt_r      <= cnt_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    err_r      <= err_nxt;
    if (in_acc) begin
      op_r   <= in_ch.operation;
      sx_r   <= in_ch.start_x;
      sy_r   <= in_ch.start_y;
      ex_r   <= in_ch.end_x;
      ey_r   <= in_ch.end_y;
      ink_r  <= in_ch.ink;
      ridx_r <= in_ch.read_index;
    end
    if (state_r == S_LRD) begin
      hit_r   <= pix.hit;
      waddr_r <= pix.idx[AW-1:0];
      bit_r   <= pix.bit_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  a_wipe_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    wipe_r |-> !in_ch.ready)
    else $error("item accepted during clearing pass");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_SWEEP || state_r == S_LWR))
    else $error("frame store written outside sweep or pixel write");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (IDX_W'(mem_waddr) < LIMIT))
    else $error("frame store write address out of range");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result raised outside finish state");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted item did not start");

endmodule
